@@ src/point_hash_set_linear_probe_macros.svh @@
// Assertion macros shared by the point hash set RTL.
// Included by the controller and datapath; no other dependencies.
`ifndef POINT_HASH_SET_LINEAR_PROBE_MACROS_SVH
`define POINT_HASH_SET_LINEAR_PROBE_MACROS_SVH

// Check a property on every rising edge outside of reset.
`define PHSLP_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Check that a condition never holds outside of reset.
`define PHSLP_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

`endif

@@ src/phslp_pkg.sv @@
// Package for the point hash set: sizes, opcodes, payload and control types.
// No dependencies; used by the controller, datapath and top level.
`timescale 1ns / 1ps
`default_nettype none

package phslp_pkg;

    localparam int TABLE_SIZE      = 1543;
    localparam int MAX_DIM         = 2;
    localparam int COORD_W         = 32;
    localparam int KEY_W           = MAX_DIM * COORD_W;
    localparam int MEM_W           = KEY_W + 1;
    localparam int BYTES_PER_COORD = 4;
    localparam int HASH_STEPS      = MAX_DIM * BYTES_PER_COORD;
    localparam int STEP_W          = $clog2(HASH_STEPS);
    localparam int SLOT_W          = $clog2(TABLE_SIZE);
    localparam int COUNT_W         = 10;
    localparam int DIM_W           = 2;
    localparam int OP_W            = 2;
    localparam int LOAD_LIMIT      = TABLE_SIZE / 2;

    localparam int HASH_A0    = 31415;
    localparam int HASH_B     = 27183;
    localparam int HASH_A_MOD = TABLE_SIZE - 1;
    localparam int AMUL_W     = $clog2(((HASH_A0 > HASH_A_MOD) ? HASH_A0 : HASH_A_MOD) + 1);

    // Reduction mod TABLE_SIZE by reciprocal: quotient estimate is exact or one low.
    localparam int PROD_W    = AMUL_W + SLOT_W + 1;
    localparam int RED_SHIFT = PROD_W;
    localparam longint unsigned RED_MULT = (64'd1 << RED_SHIFT) / TABLE_SIZE;
    localparam int RMUL_W    = $clog2(RED_MULT + 1);

    localparam logic [OP_W-1:0] OP_CONTAINS = 2'd0;
    localparam logic [OP_W-1:0] OP_INSERT   = 2'd1;
    localparam logic [OP_W-1:0] OP_DELETE   = 2'd2;

    typedef struct packed {
        logic [OP_W-1:0]           op;
        logic signed [COORD_W-1:0] coord_0;
        logic signed [COORD_W-1:0] coord_1;
    } t_in_item;

    typedef struct packed {
        logic               found;
        logic               status;
        logic [COUNT_W-1:0] entry_total;
    } t_out_item;

    typedef struct packed {
        logic load_req;
        logic hash_mul;
        logic hash_quo;
        logic hash_red;
        logic idx_adv;
        logic resolve;
        logic place_write;
        logic del_adv;
        logic del_take;
        logic clear_wr;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic clear_last;
        logic hash_last;
        logic slot_valid;
        logic key_eq;
        logic del_go;
    } t_sts;

    typedef logic [HASH_STEPS-1:0][AMUL_W-1:0] t_a_tab;

    // Hash multiplier per byte position; independent of the key.
    function automatic t_a_tab hash_a_table();
        t_a_tab tab;
        longint a;
        a = HASH_A0;
        for (int i = 0; i < HASH_STEPS; i++) begin
            tab[i] = AMUL_W'(a);
            a = (a * HASH_B) % HASH_A_MOD;
        end
        return tab;
    endfunction

    localparam t_a_tab HASH_A_TAB = hash_a_table();

endpackage

`default_nettype wire

@@ src/phslp_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module phslp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

@@ src/phslp_dp.sv @@
// Datapath of the point hash set: hash unit, probe cursor, count and table RAM.
// Depends on phslp_pkg, phslp_ram and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "point_hash_set_linear_probe_macros.svh"

module phslp_dp
    import phslp_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire t_cmd             i_cmd,
    output t_sts                  o_sts,
    input  wire t_in_item         i_in_data,
    input  wire logic             i_cfg_we,
    input  wire logic [DIM_W-1:0] i_cfg_data,
    output t_out_item             o_out_data
);

    logic [DIM_W-1:0]        r_dim;
    logic [OP_W-1:0]         r_op;
    logic [KEY_W-1:0]        r_key;
    logic [SLOT_W-1:0]       r_r;
    logic [STEP_W-1:0]       r_step;
    logic [PROD_W-1:0]       r_x;
    logic [RMUL_W-1:0]       r_q;
    logic [SLOT_W-1:0]       r_idx;
    logic [SLOT_W-1:0]       r_pos;
    logic [SLOT_W-1:0]       r_clr;
    logic [COUNT_W-1:0]      r_count;
    logic [COUNT_W-1:0]      n_count;
    logic                    r_found;
    logic                    r_status;
    t_out_item               r_out;

    logic                    dim2;
    logic [STEP_W-1:0]       last_step;
    logic [7:0]              cur_byte;
    logic [PROD_W-1:0]       x_next;
    logic [PROD_W+RMUL_W-1:0] quo_prod;
    logic [PROD_W-1:0]       rem_full;
    logic [SLOT_W:0]         rem;
    logic [SLOT_W-1:0]       red;
    logic [SLOT_W-1:0]       idx_next;
    logic [SLOT_W-1:0]       pos_next;
    logic [MEM_W-1:0]        rdata;
    logic                    rd_valid;
    logic [KEY_W-1:0]        rd_key;
    logic                    key_eq;
    logic                    hit;
    logic                    full;
    logic                    ins_go;
    logic                    del_go;
    logic                    we;
    logic [SLOT_W-1:0]       waddr;
    logic [MEM_W-1:0]        wdata;
    logic [SLOT_W-1:0]       raddr;

    // Dimension codes below one act as one, above two act as two.
    assign dim2      = (r_dim >= DIM_W'(MAX_DIM));
    assign last_step = dim2 ? STEP_W'(HASH_STEPS - 1) : STEP_W'(BYTES_PER_COORD - 1);
    assign cur_byte  = r_key[{r_step, 3'b000} +: 8];

    assign x_next   = PROD_W'(HASH_A_TAB[r_step]) * PROD_W'(r_r) + PROD_W'(cur_byte);
    assign quo_prod = (PROD_W+RMUL_W)'(r_x) * (PROD_W+RMUL_W)'(RED_MULT);
    assign rem_full = r_x - PROD_W'(r_q) * PROD_W'(TABLE_SIZE);
    assign rem      = rem_full[SLOT_W:0];
    assign red      = (rem >= (SLOT_W+1)'(TABLE_SIZE)) ? SLOT_W'(rem - (SLOT_W+1)'(TABLE_SIZE))
                                                       : rem[SLOT_W-1:0];

    assign idx_next = (r_idx == SLOT_W'(TABLE_SIZE - 1)) ? '0 : r_idx + 1'b1;
    assign pos_next = (r_pos == SLOT_W'(TABLE_SIZE - 1)) ? '0 : r_pos + 1'b1;

    assign rd_valid = rdata[KEY_W];
    assign rd_key   = rdata[KEY_W-1:0];
    assign key_eq   = dim2 ? (rd_key == r_key) : (rd_key[COORD_W-1:0] == r_key[COORD_W-1:0]);
    assign hit      = rd_valid & key_eq;
    assign full     = (r_count >= COUNT_W'(LOAD_LIMIT));
    assign ins_go   = (r_op == OP_INSERT) & ~hit & ~full;
    assign del_go   = (r_op == OP_DELETE) & hit;

    always_comb begin
        we    = 1'b0;
        waddr = r_idx;
        wdata = {1'b1, r_key};
        if (i_cmd.clear_wr) begin
            we    = 1'b1;
            waddr = r_clr;
            wdata = '0;
        end else if (i_cmd.resolve) begin
            we    = ins_go | del_go;
            wdata = {~del_go, r_key};
        end else if (i_cmd.place_write) begin
            we    = ~rd_valid;
        end else if (i_cmd.del_take) begin
            we    = 1'b1;
            waddr = r_pos;
            wdata = '0;
        end
    end

    assign raddr = i_cmd.del_adv ? pos_next : r_idx;

    phslp_ram #(
        .WIDTH (MEM_W),
        .DEPTH (TABLE_SIZE)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    always_comb begin
        n_count = r_count;
        if (i_cmd.resolve && ins_go) begin
            n_count = r_count + 1'b1;
        end else if ((i_cmd.resolve && del_go) || i_cmd.del_take) begin
            n_count = r_count - 1'b1;
        end else if (i_cmd.place_write && !rd_valid) begin
            n_count = r_count + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dim   <= DIM_W'(1);
            r_count <= '0;
            r_clr   <= '0;
        end else begin
            if (i_cfg_we) begin
                r_dim <= i_cfg_data;
            end
            r_count <= n_count;
            if (i_cmd.clear_wr) begin
                r_clr <= r_clr + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_req) begin
            r_op  <= i_in_data.op;
            r_key <= {i_in_data.coord_1, i_in_data.coord_0};
        end else if (i_cmd.del_take) begin
            r_key <= rd_key;
        end
        if (i_cmd.load_req || i_cmd.del_take) begin
            r_r    <= '0;
            r_step <= '0;
        end
        if (i_cmd.hash_mul) begin
            r_x <= x_next;
        end
        if (i_cmd.hash_quo) begin
            r_q <= RMUL_W'(quo_prod >> RED_SHIFT);
        end
        if (i_cmd.hash_red) begin
            r_r    <= red;
            r_step <= r_step + 1'b1;
            r_idx  <= red;
        end else if (i_cmd.idx_adv) begin
            r_idx <= idx_next;
        end
        if (i_cmd.resolve) begin
            r_found  <= hit;
            r_status <= (r_op == OP_INSERT) & ~hit & full;
            r_pos    <= r_idx;
        end else if (i_cmd.del_adv) begin
            r_pos <= pos_next;
        end
        if (i_cmd.out_load) begin
            r_out.found       <= r_found;
            r_out.status      <= r_status;
            r_out.entry_total <= r_count;
        end
    end

    assign o_sts.clear_last = (r_clr == SLOT_W'(TABLE_SIZE - 1));
    assign o_sts.hash_last  = (r_step == last_step);
    assign o_sts.slot_valid = rd_valid;
    assign o_sts.key_eq     = key_eq;
    assign o_sts.del_go     = del_go;
    assign o_out_data       = r_out;

    `PHSLP_ASSERT(a_count_bound, i_clk, i_rst_n, r_count <= COUNT_W'(LOAD_LIMIT), "entry count above load limit")
    `PHSLP_ASSERT(a_reduce_range, i_clk, i_rst_n, i_cmd.hash_red |=> r_r < SLOT_W'(TABLE_SIZE), "hash residue out of range")

endmodule

`default_nettype wire

@@ src/phslp_ctrl.sv @@
// Controller of the point hash set: sequences clear, hash, probe and cluster repair.
// Depends on phslp_pkg and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "point_hash_set_linear_probe_macros.svh"

module phslp_ctrl
    import phslp_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    output logic      o_in_stall,
    input  wire logic i_out_stall,
    output logic      o_out_valid,
    input  wire t_sts i_sts,
    output t_cmd      o_cmd
);

    typedef enum logic [9:0] {
        S_CLEAR   = 10'b0000000001,
        S_IDLE    = 10'b0000000010,
        S_HMUL    = 10'b0000000100,
        S_HQUO    = 10'b0000001000,
        S_HRED    = 10'b0000010000,
        S_PRD     = 10'b0000100000,
        S_PCHK    = 10'b0001000000,
        S_DEL_RD  = 10'b0010000000,
        S_DEL_CHK = 10'b0100000000,
        S_DONE    = 10'b1000000000
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_placing;
    logic   n_placing;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   out_free;

    assign out_free = ~r_out_valid | ~i_out_stall;

    always_comb begin
        n_state     = r_state;
        n_placing   = r_placing;
        n_out_valid = r_out_valid & i_out_stall;
        o_cmd       = '0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clear_wr = 1'b1;
                if (i_sts.clear_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_req = 1'b1;
                    n_placing      = 1'b0;
                    n_state        = S_HMUL;
                end
            end
            S_HMUL: begin
                o_cmd.hash_mul = 1'b1;
                n_state        = S_HQUO;
            end
            S_HQUO: begin
                o_cmd.hash_quo = 1'b1;
                n_state        = S_HRED;
            end
            S_HRED: begin
                o_cmd.hash_red = 1'b1;
                n_state        = i_sts.hash_last ? S_PRD : S_HMUL;
            end
            S_PRD: begin
                n_state = S_PCHK;
            end
            S_PCHK: begin
                // Stop on the key itself or on the first empty slot.
                if (!i_sts.slot_valid || i_sts.key_eq) begin
                    if (r_placing) begin
                        o_cmd.place_write = 1'b1;
                        n_state           = S_DEL_RD;
                    end else begin
                        o_cmd.resolve = 1'b1;
                        n_state       = i_sts.del_go ? S_DEL_RD : S_DONE;
                    end
                end else begin
                    o_cmd.idx_adv = 1'b1;
                    n_state       = S_PRD;
                end
            end
            S_DEL_RD: begin
                o_cmd.del_adv = 1'b1;
                n_state       = S_DEL_CHK;
            end
            S_DEL_CHK: begin
                // Pull the next cluster entry and re-place it.
                if (i_sts.slot_valid) begin
                    o_cmd.del_take = 1'b1;
                    n_placing      = 1'b1;
                    n_state        = S_HMUL;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_placing   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_placing   <= n_placing;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

    `PHSLP_ASSERT(a_load_when_free, i_clk, i_rst_n, o_cmd.out_load |-> out_free, "result loaded over a pending transaction")
    `PHSLP_ASSERT(a_done_delivers, i_clk, i_rst_n, (r_state == S_DONE) && !r_out_valid |=> r_out_valid, "finished result not presented")

endmodule

`default_nettype wire

@@ src/point_hash_set_linear_probe.sv @@
// Top level of the point hash set with linear probing.
// Depends on phslp_pkg, phslp_ctrl and phslp_dp.
//
// Usage:
//  Input channel (i_in_valid / o_in_stall / i_in_data) carries one transaction
//  per request: op (contains, insert, delete) and one point. The output channel
//  (o_out_valid / i_out_stall / o_out_data) returns one transaction per request:
//  found, status (set on an insert that would pass half load) and entry_total.
//  i_cfg_we / i_cfg_data set the number of hashed coordinates; write only idle.
// Sequencing:
//  Hashing runs a multiply, quotient and reduce step per key byte in the shared
//  hash unit (four bytes for one coordinate, eight for two), then a read and a
//  check per table slot probed on the single table RAM, plus accept and result
//  load. A delete adds, for every entry of the following cluster, one rehash
//  and probe of that entry. One request is in flight at a time.
// Reset: synchronous, active low. After reset the table RAM is cleared one
//  slot per cycle through all slots, with o_in_stall high; config writes are taken.
// Stall: a finished result holds in the output register while i_out_stall is
//  high; the next request is accepted and processed meanwhile, and it waits at
//  the end only if the previous result is still held.
`timescale 1ns / 1ps
`default_nettype none

module point_hash_set_linear_probe
    import phslp_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output logic                  o_in_stall,
    input  wire t_in_item         i_in_data,
    output logic                  o_out_valid,
    input  wire logic             i_out_stall,
    output t_out_item             o_out_data,
    input  wire logic             i_cfg_we,
    input  wire logic [DIM_W-1:0] i_cfg_data
);

    // Command and status between controller and datapath.
    t_cmd cmd;
    t_sts sts;

    phslp_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    phslp_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .i_in_data  (i_in_data),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .o_out_data (o_out_data)
    );

endmodule

`default_nettype wire

@@ bench/testbench.sv @@
// Self-checking bench for point_hash_set_linear_probe: requests go in with random gaps,
// a predictor of the probed hash table works out every result, and a monitor compares them.
// Depends on phslp_pkg and the RTL of the block.
`timescale 1ns / 1ps

module testbench;
    import phslp_pkg::*;

    localparam int TSIZE = 1543;

    logic i_clk;
    logic i_rst_n;
    logic in_valid;
    logic in_stall;
    t_in_item in_data;
    logic out_valid;
    logic out_stall;
    t_out_item out_data;
    logic cfg_we;
    logic [DIM_W-1:0] cfg_data;

    point_hash_set_linear_probe dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in_valid(in_valid),
        .o_in_stall(in_stall),
        .i_in_data(in_data),
        .o_out_valid(out_valid),
        .i_out_stall(out_stall),
        .o_out_data(out_data),
        .i_cfg_we(cfg_we),
        .i_cfg_data(cfg_data)
    );

    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    // Shadow copy of the table.
    logic [63:0] shadow_key [TSIZE];
    bit shadow_used [TSIZE];
    int unsigned point_count;
    logic [1:0] dim_reg;

    t_out_item pending_results[$];
    int errors;
    bit quiet;         // no idling on either side
    int recent_keys_n;
    logic [63:0] recent_keys[$];

    function automatic int unsigned eff_dim();
        if (dim_reg < 1) return 1;
        if (dim_reg > 2) return 2;
        return dim_reg;
    endfunction

    function automatic bit same_point(logic [63:0] x, logic [63:0] y, int unsigned d);
        if (d >= 2) return x == y;
        return x[31:0] == y[31:0];
    endfunction

    function automatic int unsigned home_of(logic [63:0] key, int unsigned d);
        longint unsigned r, a;
        r = 0;
        a = 31415;
        for (int i = 0; i < 4 * d; i++) begin
            r = (a * r + key[8*i +: 8]) % TSIZE;
            a = (a * 27183) % (TSIZE - 1);
        end
        return r;
    endfunction

    function automatic int unsigned probe_slot(logic [63:0] key, int unsigned d);
        int unsigned i;
        i = home_of(key, d);
        for (int s = 0; s < TSIZE; s++) begin
            if (!shadow_used[i] || same_point(shadow_key[i], key, d)) return i;
            i = (i + 1 == TSIZE) ? 0 : i + 1;
        end
        return i;
    endfunction

    function automatic void replace_entry(logic [63:0] key, int unsigned d);
        int unsigned p;
        p = probe_slot(key, d);
        if (shadow_used[p]) return;  // equal entry already there: merge
        shadow_key[p] = key;
        shadow_used[p] = 1;
        point_count++;
    endfunction

    // Apply one request to the shadow table and return its result.
    function automatic t_out_item apply_request(t_in_item req);
        t_out_item res;
        int unsigned d, pos, i;
        logic [63:0] key, moved;
        bit hit;
        d = eff_dim();
        key = {req.coord_1, req.coord_0};
        pos = probe_slot(key, d);
        hit = shadow_used[pos] && same_point(shadow_key[pos], key, d);
        res.status = 1'b0;
        if (req.op == OP_INSERT && !hit) begin
            if (2 * (point_count + 1) > TSIZE || shadow_used[pos]) begin
                res.status = 1'b1;
            end else begin
                shadow_key[pos] = key;
                shadow_used[pos] = 1;
                point_count++;
            end
        end else if (req.op == OP_DELETE && hit) begin
            i = pos;
            shadow_used[pos] = 0;
            point_count--;
            for (int s = 0; s < TSIZE; s++) begin
                i = (i + 1 == TSIZE) ? 0 : i + 1;
                if (!shadow_used[i]) break;
                moved = shadow_key[i];
                shadow_used[i] = 0;
                point_count--;
                replace_entry(moved, d);
            end
        end
        res.found = hit;
        res.entry_total = point_count[COUNT_W-1:0];
        return res;
    endfunction

    // Send one request; the predictor runs at acceptance.
    task automatic send_request(logic [1:0] op, logic [31:0] c0, logic [31:0] c1);
        t_in_item req;
        if (!quiet && $urandom_range(0, 3) == 0) begin
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
        req.op = op;
        req.coord_0 = c0;
        req.coord_1 = c1;
        in_data <= req;
        in_valid <= 1'b1;
        @(posedge i_clk);
        while (in_stall) @(posedge i_clk);
        pending_results.push_back(apply_request(req));
        if (recent_keys.size() > 40) void'(recent_keys.pop_front());
        recent_keys.push_back({c1, c0});
        // Drop valid; the block is busy with this request anyway.
        in_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Receiver: random stall bursts.
    initial begin
        out_stall = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(posedge i_clk);
            if (quiet) begin
                out_stall <= 1'b0;
            end else if ($urandom_range(0, 5) == 0) begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 8)) @(posedge i_clk);
                out_stall <= 1'b0;
            end
        end
    end

    // Check each result transaction against the oldest expectation.
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && out_valid && !out_stall) begin
            if (pending_results.size() == 0) begin
                $error("unexpected result transaction");
                errors++;
            end else begin
                want = pending_results.pop_front();
                if (out_data.found !== want.found) begin
                    $error("found: expected %0d actual %0d", want.found, out_data.found);
                    errors++;
                end
                if (out_data.status !== want.status) begin
                    $error("status: expected %0d actual %0d", want.status, out_data.status);
                    errors++;
                end
                if (out_data.entry_total !== want.entry_total) begin
                    $error("entry_total: expected %0d actual %0d",
                           want.entry_total, out_data.entry_total);
                    errors++;
                end
            end
        end
    end

    task automatic drain();
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
    endtask

    // Change the dimension register with the block idle.
    task automatic write_dim(logic [1:0] value);
        drain();
        cfg_data <= value;
        cfg_we <= 1'b1;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        dim_reg = value;
    endtask

    function automatic logic [31:0] pick_coord();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return $urandom_range(0, 15);
            3: return 32'hffff_ffff;
            default: return $urandom();
        endcase
    endfunction

    task automatic test_directed();
        send_request(OP_CONTAINS, 32'h0, 32'h0);
        send_request(OP_INSERT, 32'h0, 32'h0);
        send_request(OP_INSERT, 32'h0, 32'h0);          // duplicate insert
        send_request(OP_INSERT, 32'h8000_0000, 32'h0);
        send_request(OP_INSERT, 32'h7fff_ffff, 32'hffff_ffff);
        send_request(OP_INSERT, 32'hffff_ffff, 32'h8000_0000);
        send_request(OP_CONTAINS, 32'h7fff_ffff, 32'h1234);
        send_request(2'd3, 32'h7fff_ffff, 32'h0);       // unused opcode
        send_request(OP_DELETE, 32'h5555_aaaa, 32'h0);  // absent
        send_request(OP_DELETE, 32'h0, 32'h0);
        send_request(OP_CONTAINS, 32'h0, 32'h0);
        send_request(OP_DELETE, 32'h8000_0000, 32'hffff_ffff);
    endtask

    // Fill past half load so inserts are refused, then delete every other point.
    task automatic test_full_table();
        for (int k = 0; k < 790; k++) send_request(OP_INSERT, k * 7 + 3, 32'h0);
        for (int k = 0; k < 790; k += 2) send_request(OP_DELETE, k * 7 + 3, 32'h0);
    endtask

    task automatic random_mix(int n, bit dense);
        logic [31:0] c0, c1;
        logic [63:0] k;
        for (int j = 0; j < n; j++) begin
            if (recent_keys.size() > 0 && $urandom_range(0, 1) == 0) begin
                k = recent_keys[$urandom_range(0, recent_keys.size() - 1)];
                c0 = k[31:0];
                c1 = ($urandom_range(0, 3) == 0) ? $urandom() : k[63:32];
            end else if (dense) begin
                c0 = $urandom_range(0, 63);
                c1 = $urandom_range(0, 3);
            end else begin
                c0 = pick_coord();
                c1 = pick_coord();
            end
            send_request($urandom_range(0, 3), c0, c1);
        end
    endtask

    // Points stored under two coordinates, then viewed with one: merges on delete.
    task automatic test_dim_change();
        write_dim(2'd2);
        for (int k = 0; k < 12; k++) send_request(OP_INSERT, k % 4, k);
        write_dim(2'd1);
        for (int k = 0; k < 6; k++) send_request(OP_DELETE, k % 4, 32'h0);
        random_mix(40, 1);
    endtask

    initial begin
        errors = 0;
        quiet = 0;
        in_valid = 1'b0;
        in_data = '0;
        cfg_we = 1'b0;
        cfg_data = 2'd1;
        i_rst_n = 1'b0;
        dim_reg = 2'd1;
        point_count = 0;
        for (int s = 0; s < TSIZE; s++) begin
            shadow_used[s] = 0;
            shadow_key[s] = '0;
        end
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_dim_change();
        write_dim(2'd0);
        random_mix(80, 1);
        write_dim(2'd3);
        random_mix(80, 1);
        write_dim(2'd1);
        test_full_table();
        drain();
        write_dim(2'd2);
        random_mix(40, 0);
        random_mix(40, 1);
        write_dim(2'd1);
        random_mix(30, 1);
        quiet = 1;
        write_dim(2'd2);
        random_mix(30, 1);

        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (errors == 0 && pending_results.size() == 0) begin
            $display("point_hash_set_linear_probe: match");
        end else begin
            $display("point_hash_set_linear_probe: mismatch");
        end
        $finish;
    end

    // Delete chains can walk long clusters; allow plenty.
    initial begin
        #400ms;
        $display("point_hash_set_linear_probe: mismatch");
        $finish;
    end

endmodule
